/* sv/vector_magnitude_limit_2d_unit_defines.svh */
// Assertion macros for the 2D vector magnitude limiter.
// They are included by the top level, which must provide clk and arst_n.
`ifndef VECTOR_MAGNITUDE_LIMIT_2D_UNIT_DEFINES_SVH
`define VECTOR_MAGNITUDE_LIMIT_2D_UNIT_DEFINES_SVH

// Same-cycle implication, checked while out of reset.
`define VML_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked while out of reset.
`define VML_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/vml_pkg.sv */
// Shared types and constants for the 2D vector magnitude limiter.
// No dependencies; used by every module of the block.
`default_nettype none
package vml_pkg;
	localparam int CW = 16;            // component width
	localparam int LW = CW - 1;        // limit width
	localparam int SW = 2 * CW;        // width of the sum of squares
	localparam int RW = CW;            // root width, one bit per stage
	localparam int QW = CW - 1;        // quotient width, one bit per stage
	localparam int NW = CW + LW;       // dividend width, |comp| * limit
	localparam int PIPE_LEN = RW + QW + 4;

	typedef struct packed {
		logic signed [CW-1:0] in_x;
		logic signed [CW-1:0] in_y;
		logic [LW-1:0]        limit;
	} vec_t;

	typedef struct packed {
		logic signed [CW-1:0] out_x;
		logic signed [CW-1:0] out_y;
		logic                 was_clamped;
	} res_t;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic [LW-1:0]        lim;
		logic [CW-1:0]        ax;
		logic [CW-1:0]        ay;
		logic                 clamp;
	} side_t;
endpackage
`default_nettype wire

/* sv/vector_magnitude_limit_2d_unit.sv */
// Top level of the 2D vector magnitude limiter.
// Depends on vml_pkg, vml_isqrt, vml_div and the assertion macro header.
//
//   Channel   Valid       Stall       Payload
//   request   vec_valid   vec_stall   vec (in_x, in_y, limit)
//   result    res_valid   res_stall   res (out_x, out_y, was_clamped)
//
// One request enters per cycle unless the result side stalls, and passes through
// PIPE_LEN (35) register stages; its result is presented on res from the last stage.
// The pipeline length is set by the square root (one bit per stage) and the two
// dividers (one quotient bit per stage), which form the bulk of the pipeline.
// Reset clears only the valid bits; data registers are left alone.
// A stalled result freezes the whole pipeline, so the request side stalls too.
`default_nettype none
`include "vector_magnitude_limit_2d_unit_defines.svh"
module vector_magnitude_limit_2d_unit (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          vec_valid,
	output logic               vec_stall,
	input  wire vml_pkg::vec_t vec,
	output logic               res_valid,
	input  wire logic          res_stall,
	output vml_pkg::res_t      res
);
	import vml_pkg::*;

	// One valid bit per stage; the pipeline moves as a whole.
	logic [PIPE_LEN-1:0] vld_q;
	logic                adv;

	// Stage 1: magnitudes and squares. Stage 2: sum and compare.
	logic [CW-1:0]   ax_c, ay_c;
	side_t           sb_s1, sb_s2, sb_s3;
	logic [SW-1:0]   sqx_s1, sqy_s1, sum_s2;
	logic [2*LW-1:0] limsq_s1;
	side_t           sqsb_q [RW];
	side_t           divsb_q [QW];
	logic [RW-1:0]   root;
	logic [CW-1:0]   mag_s3;
	logic [NW-1:0]   numx_s3, numy_s3;
	logic [QW-1:0]   qx, qy;
	side_t           fin;
	res_t            res_q;

	assign adv       = !(vld_q[PIPE_LEN-1] && res_stall);
	assign vec_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[PIPE_LEN-2:0], vec_valid};
		end
	end

	// Absolute values; the most negative input maps to 2^(CW-1) as an unsigned value.
	assign ax_c = vec.in_x[CW-1] ? (~vec.in_x + 1'b1) : vec.in_x;
	assign ay_c = vec.in_y[CW-1] ? (~vec.in_y + 1'b1) : vec.in_y;

	always_ff @(posedge clk) begin
		if (adv) begin
			sb_s1.x     <= vec.in_x;
			sb_s1.y     <= vec.in_y;
			sb_s1.lim   <= vec.limit;
			sb_s1.ax    <= ax_c;
			sb_s1.ay    <= ay_c;
			sb_s1.clamp <= 1'b0;
			sqx_s1      <= ax_c * ax_c;
			sqy_s1      <= ay_c * ay_c;
			limsq_s1    <= vec.limit * vec.limit;
		end
	end

	// The sum reaches at most 2^(SW-1), so it fits without a carry bit.
	always_ff @(posedge clk) begin
		if (adv) begin
			sum_s2       <= sqx_s1 + sqy_s1;
			sb_s2.x      <= sb_s1.x;
			sb_s2.y      <= sb_s1.y;
			sb_s2.lim    <= sb_s1.lim;
			sb_s2.ax     <= sb_s1.ax;
			sb_s2.ay     <= sb_s1.ay;
			sb_s2.clamp  <= (sqx_s1 + sqy_s1) > SW'(limsq_s1);
		end
	end

	vml_isqrt u_isqrt (
		.clk  (clk),
		.en   (adv),
		.rad  (sum_s2),
		.root (root)
	);

	// The side data walks alongside the root stages.
	always_ff @(posedge clk) begin
		if (adv) begin
			sqsb_q[0] <= sb_s2;
			for (int k = 1; k < RW; k++) begin
				sqsb_q[k] <= sqsb_q[k-1];
			end
		end
	end

	// Stage 3: dividends |comp| * limit and a divisor never below one.
	always_ff @(posedge clk) begin
		if (adv) begin
			sb_s3   <= sqsb_q[RW-1];
			mag_s3  <= (root == '0) ? CW'(1) : root;
			numx_s3 <= sqsb_q[RW-1].ax * sqsb_q[RW-1].lim;
			numy_s3 <= sqsb_q[RW-1].ay * sqsb_q[RW-1].lim;
		end
	end

	vml_div u_div_x (
		.clk (clk),
		.en  (adv),
		.num (numx_s3),
		.den (mag_s3),
		.quo (qx)
	);

	vml_div u_div_y (
		.clk (clk),
		.en  (adv),
		.num (numy_s3),
		.den (mag_s3),
		.quo (qy)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			divsb_q[0] <= sb_s3;
			for (int k = 1; k < QW; k++) begin
				divsb_q[k] <= divsb_q[k-1];
			end
		end
	end

	assign fin = divsb_q[QW-1];

	// Final stage: reapply the signs, or pass the vector through when it is in range.
	// Since |comp| never exceeds the magnitude, the quotient stays within limit,
	// which always fits the signed range.
	always_ff @(posedge clk) begin
		if (adv) begin
			res_q.was_clamped <= fin.clamp;
			if (fin.clamp) begin
				res_q.out_x <= fin.x[CW-1] ? (~{1'b0, qx} + 1'b1) : {1'b0, qx};
				res_q.out_y <= fin.y[CW-1] ? (~{1'b0, qy} + 1'b1) : {1'b0, qy};
			end else begin
				res_q.out_x <= fin.x;
				res_q.out_y <= fin.y;
			end
		end
	end

	assign res_valid = vld_q[PIPE_LEN-1];
	assign res       = res_q;

	// A request taken at the port must show up in the first stage.
	`VML_ASSERT_NEXT(a_enter, vec_valid && !vec_stall, vld_q[0], "accepted request lost at entry")
	// A held result must freeze the request side.
	`VML_ASSERT_NOW(a_freeze, res_valid && res_stall, vec_stall, "pipeline not frozen on stall")
	// A stalled result is still offered in the next cycle.
	`VML_ASSERT_NEXT(a_hold, res_valid && res_stall, res_valid, "held result dropped")
endmodule
`default_nettype wire

/* sv/vml_isqrt.sv */
// Pipelined integer square root, one root bit per stage.
// Depends on vml_pkg.
`default_nettype none
module vml_isqrt (
	input  wire logic                   clk,
	input  wire logic                   en,
	input  wire logic [vml_pkg::SW-1:0] rad,
	output logic      [vml_pkg::RW-1:0] root
);
	import vml_pkg::*;

	logic [SW-1:0] rem_s1  [RW];
	logic [RW-1:0] root_s1 [RW];
	logic [SW-1:0] rem_n   [RW];
	logic [RW-1:0] root_n  [RW];
	logic [SW-1:0] prem    [RW];
	logic [RW-1:0] proot   [RW];
	logic [SW+1:0] inc     [RW];

	// Stage k settles bit RW-1-k; rem holds rad minus the square of the partial root.
	always_comb begin
		for (int k = 0; k < RW; k++) begin
			prem[k]  = (k == 0) ? rad : rem_s1[(k == 0) ? 0 : k - 1];
			proot[k] = (k == 0) ? '0 : root_s1[(k == 0) ? 0 : k - 1];
			inc[k]   = ((SW+2)'(proot[k]) << (RW - k)) + ((SW+2)'(1) << (2 * (RW - 1 - k)));
			if ({2'b00, prem[k]} >= inc[k]) begin
				rem_n[k]  = prem[k] - inc[k][SW-1:0];
				root_n[k] = proot[k] | (RW'(1) << (RW - 1 - k));
			end else begin
				rem_n[k]  = prem[k];
				root_n[k] = proot[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < RW; k++) begin
				rem_s1[k]  <= rem_n[k];
				root_s1[k] <= root_n[k];
			end
		end
	end

	assign root = root_s1[RW-1];
endmodule
`default_nettype wire

/* sv/vml_div.sv */
// Pipelined restoring divider, one quotient bit per stage.
// Depends on vml_pkg; the quotient is known to fit in QW bits.
`default_nettype none
module vml_div (
	input  wire logic                   clk,
	input  wire logic                   en,
	input  wire logic [vml_pkg::NW-1:0] num,
	input  wire logic [vml_pkg::CW-1:0] den,
	output logic      [vml_pkg::QW-1:0] quo
);
	import vml_pkg::*;

	logic [NW-1:0] rem_s1 [QW];
	logic [CW-1:0] den_s1 [QW];
	logic [QW-1:0] quo_s1 [QW];
	logic [NW-1:0] rem_n  [QW];
	logic [QW-1:0] quo_n  [QW];
	logic [NW-1:0] prem   [QW];
	logic [CW-1:0] pden   [QW];
	logic [QW-1:0] pquo   [QW];
	logic [NW-1:0] shd    [QW];

	always_comb begin
		for (int k = 0; k < QW; k++) begin
			prem[k] = (k == 0) ? num : rem_s1[(k == 0) ? 0 : k - 1];
			pden[k] = (k == 0) ? den : den_s1[(k == 0) ? 0 : k - 1];
			pquo[k] = (k == 0) ? '0  : quo_s1[(k == 0) ? 0 : k - 1];
			shd[k]  = NW'(pden[k]) << (QW - 1 - k);
			if (prem[k] >= shd[k]) begin
				rem_n[k] = prem[k] - shd[k];
				quo_n[k] = {pquo[k][QW-2:0], 1'b1};
			end else begin
				rem_n[k] = prem[k];
				quo_n[k] = {pquo[k][QW-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < QW; k++) begin
				rem_s1[k] <= rem_n[k];
				den_s1[k] <= pden[k];
				quo_s1[k] <= quo_n[k];
			end
		end
	end

	assign quo = quo_s1[QW-1];
endmodule
`default_nettype wire
